// File: design/enum_rom_descriptor_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the enumeration ROM descriptor parser
// Shared concurrent check forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ENUM_ROM_DESCRIPTOR_PARSER_CORE_MACROS_SVH
`define ENUM_ROM_DESCRIPTOR_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define ERDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erdp: same-cycle check failed");

// next-cycle implication
`define ERDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erdp: next-cycle check failed");

`endif

// File: design/erdp_pkg.sv
// ----------------------------------------------------------------------------
// erdp_pkg
// Shared types and codes for the enumeration ROM descriptor parser.
// ----------------------------------------------------------------------------
package erdp_pkg;

    // descriptor type nibble codes
    localparam logic [3:0] DK_COMP  = 4'h1;
    localparam logic [3:0] DK_MPORT = 4'h3;
    localparam logic [3:0] DK_END   = 4'hf;
    localparam logic [2:0] DK_ADDR  = 3'b101;   // bit 3 is don't-care

    // address descriptor size codes
    localparam logic [1:0] SZ_8K  = 2'd1;
    localparam logic [1:0] SZ_ANY = 2'd3;

    // slave kinds
    localparam logic [1:0] SK_SLAVE   = 2'd0;
    localparam logic [1:0] SK_SWRAP   = 2'd2;
    localparam logic [1:0] SK_MWRAP   = 2'd3;

    // result event codes
    localparam logic [1:0] EV_CORE      = 2'd0;
    localparam logic [1:0] EV_END       = 2'd1;
    localparam logic [1:0] EV_MALFORMED = 2'd2;
    localparam logic [1:0] EV_FULL      = 2'd3;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PMU = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GCI = 1'b1;
    localparam logic [11:0] PMU_ID_RESET = 12'd2087;
    localparam logic [11:0] GCI_ID_RESET = 12'd2112;

    // word queue, depth a power of two
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified descriptor word
    typedef struct packed {
        logic        begin_scan;
        logic        is_end;
        logic        is_comp;
        logic        is_mport;
        logic        is_addr;
        logic        addr_high;
        logic [1:0]  size_kind;
        logic [1:0]  slave_kind;
        logic        no_wrap;
        logic [11:0] part;
        logic [7:0]  revision;
        logic [19:0] region;
    } erdp_word_t;

endpackage

// File: design/erdp_front.sv
// ----------------------------------------------------------------------------
// erdp_front
// Input handshake and descriptor word classification.
// ----------------------------------------------------------------------------
module erdp_front
    import erdp_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] descriptor_word,
    input  logic        q_full,
    output logic        push,
    output erdp_word_t  push_word
);

    logic [3:0] nib;

    assign nib      = descriptor_word[3:0];
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_word.begin_scan = command;
        push_word.is_end     = (nib == DK_END);
        push_word.is_comp    = (nib == DK_COMP);
        push_word.is_mport   = (nib == DK_MPORT);
        push_word.is_addr    = (nib[2:0] == DK_ADDR);
        push_word.addr_high  = descriptor_word[3];
        push_word.size_kind  = descriptor_word[5:4];
        push_word.slave_kind = descriptor_word[7:6];
        // no master and no slave wrappers
        push_word.no_wrap    = (descriptor_word[23:14] == 10'd0);
        push_word.part       = descriptor_word[19:8];
        push_word.revision   = descriptor_word[31:24];
        push_word.region     = descriptor_word[31:12];
    end

endmodule

// File: design/erdp_queue.sv
// ----------------------------------------------------------------------------
// erdp_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module erdp_queue
    import erdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  erdp_word_t push_word,
    output logic       q_full,
    input  logic       pop,
    output logic       q_valid,
    output erdp_word_t q_word
);

    erdp_word_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: design/erdp_back.sv
// ----------------------------------------------------------------------------
// erdp_back
// Scan state machine, core table count and registered result stage.
// ----------------------------------------------------------------------------
`include "enum_rom_descriptor_parser_core_macros.svh"

module erdp_back
    import erdp_pkg::*;
#(
    parameter int MAX_CORES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  erdp_word_t  q_word,
    output logic        q_pop,
    input  logic [11:0] pmu_core_id,
    input  logic [11:0] gci_core_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [11:0] core_id,
    output logic [7:0]  core_revision,
    output logic [31:0] base_address,
    output logic [31:0] wrap_address,
    output logic [4:0]  cores_found
);

    localparam int unsigned CNT_W = $clog2(MAX_CORES + 1);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_COMP1 = 5'b00010,
        PH_COMP2 = 5'b00100,
        PH_FIRST = 5'b01000,
        PH_SCAN  = 5'b10000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [11:0]        part_reg, part_next;
    logic [7:0]         rev_reg, rev_next;
    logic               master_reg, master_next;
    logic [19:0]        base_reg, base_next;
    logic [19:0]        wrap_reg, wrap_next;
    logic               skip_reg, skip_next;
    logic               expect_reg, expect_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               fire;
    phase_t             ph;
    logic               check;
    logic               enter;
    logic               enter_comp;
    logic [1:0]         wrap_kind;

    logic               res_valid;
    logic [1:0]         res_event;
    logic [11:0]        res_id;
    logic [7:0]         res_rev;
    logic [19:0]        res_base;
    logic [19:0]        res_wrap;
    logic [4:0]         res_count;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         event_reg;
    logic [11:0]        id_reg;
    logic [7:0]         orev_reg;
    logic [19:0]        obase_reg;
    logic [19:0]        owrap_reg;
    logic [4:0]         ocount_reg;

    assign fire  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    always_comb
    begin
        phase_next  = phase_reg;
        part_next   = part_reg;
        rev_next    = rev_reg;
        master_next = master_reg;
        base_next   = base_reg;
        wrap_next   = wrap_reg;
        skip_next   = skip_reg;
        expect_next = expect_reg;
        count_next  = count_reg;
        ph          = phase_reg;
        check       = 1'b0;
        enter       = 1'b0;
        enter_comp  = 1'b0;
        wrap_kind   = SK_SWRAP;
        res_valid   = 1'b0;
        res_event   = EV_CORE;
        res_id      = '0;
        res_rev     = '0;
        res_base    = '0;
        res_wrap    = '0;
        res_count   = 5'(count_reg);

        if (fire && q_word.begin_scan)
        begin
            phase_next  = PH_COMP1;
            part_next   = '0;
            rev_next    = '0;
            master_next = 1'b0;
            base_next   = '0;
            wrap_next   = '0;
            skip_next   = 1'b0;
            expect_next = 1'b0;
            count_next  = '0;
        end
        else if (fire)
        begin
            // first word after the component pair picks the wrapper kind; an address
            // word is handed on to scan, any other non-port word to component search
            if (phase_reg == PH_FIRST)
            begin
                if (q_word.is_mport)
                begin
                    master_next = 1'b1;
                    phase_next  = PH_SCAN;
                    ph          = PH_IDLE;
                end
                else if (q_word.is_addr)
                begin
                    master_next = 1'b0;
                    ph          = PH_SCAN;
                end
                else
                begin
                    ph = PH_COMP1;
                end
            end
            // end marker in an address list drops the core, then ends
            if (ph == PH_SCAN && !skip_reg && !expect_reg && q_word.is_end)
            begin
                ph = PH_COMP1;
            end
            wrap_kind = master_next ? SK_MWRAP : SK_SWRAP;

            case (ph)
                PH_COMP1:
                begin
                    phase_next = PH_COMP1;
                    if (q_word.is_end)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_END;
                    end
                    else if (q_word.is_comp)
                    begin
                        part_next  = q_word.part;
                        phase_next = PH_COMP2;
                    end
                end
                PH_COMP2:
                begin
                    if (!q_word.is_comp)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_MALFORMED;
                    end
                    else
                    begin
                        rev_next = q_word.revision;
                        if (q_word.no_wrap && part_reg != pmu_core_id
                            && part_reg != gci_core_id)
                        begin
                            phase_next = PH_COMP1;
                        end
                        else
                        begin
                            base_next   = '0;
                            wrap_next   = '0;
                            skip_next   = 1'b0;
                            expect_next = 1'b0;
                            phase_next  = PH_FIRST;
                        end
                    end
                end
                PH_SCAN:
                begin
                    phase_next = PH_SCAN;
                    if (skip_reg)
                    begin
                        skip_next = 1'b0;
                        check     = 1'b1;
                    end
                    else if (expect_reg)
                    begin
                        expect_next = 1'b0;
                        skip_next   = q_word.addr_high;
                        check       = 1'b1;
                    end
                    else if (q_word.is_comp)
                    begin
                        enter      = 1'b1;
                        enter_comp = 1'b1;
                    end
                    else if (q_word.is_addr)
                    begin
                        skip_next = q_word.addr_high;
                        if (q_word.size_kind == SZ_ANY)
                        begin
                            expect_next = 1'b1;
                        end
                        else if (q_word.size_kind <= SZ_8K)
                        begin
                            if (base_reg == '0 && q_word.slave_kind == SK_SLAVE)
                            begin
                                base_next = q_word.region;
                            end
                            if (wrap_reg == '0 && q_word.slave_kind == wrap_kind)
                            begin
                                wrap_next = q_word.region;
                            end
                        end
                        check = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (check && !skip_next && !expect_next && base_next != '0
                && wrap_next != '0)
            begin
                enter = 1'b1;
            end

            if (enter)
            begin
                res_valid = 1'b1;
                if (count_reg >= CNT_W'(MAX_CORES))
                begin
                    phase_next = PH_IDLE;
                    res_event  = EV_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    phase_next = PH_COMP1;
                    res_event  = EV_CORE;
                    res_id     = part_reg;
                    res_rev    = rev_reg;
                    res_base   = base_next;
                    res_wrap   = wrap_next;
                    res_count  = 5'(count_next);
                    // a component word closing the list opens the next core
                    if (enter_comp)
                    begin
                        part_next  = q_word.part;
                        phase_next = PH_COMP2;
                    end
                end
            end
        end
    end

    assign out_valid_next = (fire && res_valid) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            part_reg      <= '0;
            rev_reg       <= '0;
            master_reg    <= 1'b0;
            base_reg      <= '0;
            wrap_reg      <= '0;
            skip_reg      <= 1'b0;
            expect_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            part_reg      <= part_next;
            rev_reg       <= rev_next;
            master_reg    <= master_next;
            base_reg      <= base_next;
            wrap_reg      <= wrap_next;
            skip_reg      <= skip_next;
            expect_reg    <= expect_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            event_reg  <= res_event;
            id_reg     <= res_id;
            orev_reg   <= res_rev;
            obase_reg  <= res_base;
            owrap_reg  <= res_wrap;
            ocount_reg <= res_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign core_id       = id_reg;
    assign core_revision = orev_reg;
    assign base_address  = {obase_reg, 12'h000};
    assign wrap_address  = {owrap_reg, 12'h000};
    assign cores_found   = ocount_reg;

    `ERDP_ASSERT_NEXT(a_core_bumps_count, clk, rst_n, fire && res_valid && (res_event == EV_CORE), count_reg == $past(count_reg) + CNT_W'(1))
    `ERDP_ASSERT_NEXT(a_stop_goes_idle, clk, rst_n, fire && res_valid && (res_event != EV_CORE), phase_reg == PH_IDLE)
    `ERDP_ASSERT_NOW(a_idle_is_quiet, clk, rst_n, fire && (phase_reg == PH_IDLE) && !q_word.begin_scan, !res_valid)
    `ERDP_ASSERT_NOW(a_no_result_overrun, clk, rst_n, out_valid_reg && !out_ready, !fire)

endmodule

// File: design/enum_rom_descriptor_parser_core.sv
// ----------------------------------------------------------------------------
// enum_rom_descriptor_parser_core: enumeration ROM descriptor parser
// Path: an accepted word waits in the queue, its result in the result register.
// Throughput: 1 word per cycle while no result is stalled, set by the scan state.
// Reset: idle until a begin command; id registers return to 2087 and 2112.
// ----------------------------------------------------------------------------
//
// Structure:
//   erdp_front  - takes words from the input channel and pre-decodes the
//                 descriptor type nibble and bit fields.
//   erdp_queue  - two-entry word queue; the input side keeps accepting until
//                 full while the back end waits on a stalled result.
//   erdp_back   - scan state machine (component pair, first descriptor,
//                 address list), core count, and the result register.
//
// The config port takes writes at any time and is always ready; writes are
// expected only while no scan word is in flight. Index CFG_PMU sets the
// power management part number, CFG_GCI the coexistence part number; other
// indexes are dropped.
module enum_rom_descriptor_parser_core
    import erdp_pkg::*;
#(
    parameter int MAX_CORES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0]          cfg_data,
    // descriptor word channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [31:0]          descriptor_word,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           event_res,
    output logic [11:0]          core_id,
    output logic [7:0]           core_revision,
    output logic [31:0]          base_address,
    output logic [31:0]          wrap_address,
    output logic [4:0]           cores_found
);

    logic [11:0] pmu_id_reg, pmu_id_next;
    logic [11:0] gci_id_reg, gci_id_next;

    logic        push;
    erdp_word_t  push_word;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    erdp_word_t  q_word;

    // config registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pmu_id_next = pmu_id_reg;
        gci_id_next = gci_id_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PMU: pmu_id_next = cfg_data;
                CFG_GCI: gci_id_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmu_id_reg <= PMU_ID_RESET;
            gci_id_reg <= GCI_ID_RESET;
        end
        else
        begin
            pmu_id_reg <= pmu_id_next;
            gci_id_reg <= gci_id_next;
        end
    end

    // front end: classify and enqueue
    erdp_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .descriptor_word (descriptor_word),
        .q_full          (q_full),
        .push            (push),
        .push_word       (push_word)
    );

    erdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    // back end: parse and report
    erdp_back #(
        .MAX_CORES (MAX_CORES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_word        (q_word),
        .q_pop         (q_pop),
        .pmu_core_id   (pmu_id_reg),
        .gci_core_id   (gci_id_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .core_id       (core_id),
        .core_revision (core_revision),
        .base_address  (base_address),
        .wrap_address  (wrap_address),
        .cores_found   (cores_found)
    );

endmodule

// File: tb/sv/enum_rom_descriptor_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enum_rom_descriptor_parser_core_tb
// Feeds enumeration ROM word streams into the parser. Streams are directed
// cases first, then randomized tables. A word-level scan tracker predicts
// each core, end, malformed and table-full report. Every report is checked
// field by field, under random idling on both the word side and the report
// side except in the quiet tail of the run.
// ----------------------------------------------------------------------------
module enum_rom_descriptor_parser_core_tb;
    import erdp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int TABLE_SLOTS  = 16;
    localparam int RANDOM_WORDS = 220;
    localparam int QUIET_WORDS  = 80;
    localparam int DRAIN_CYCLES = 8;

    // codes the package leaves unnamed
    localparam logic [3:0] KIND_ADDR = {1'b0, DK_ADDR};
    localparam logic [1:0] SZ_4K     = 2'd0;
    localparam logic [1:0] SZ_16K    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COMP1,
        PH_COMP2,
        PH_FIRST,
        PH_SCAN
    } scan_phase_t;

    typedef struct {
        logic [1:0]  ev;
        logic [11:0] id;
        logic [7:0]  rev;
        logic [31:0] base;
        logic [31:0] wrap;
        logic [4:0]  count;
    } core_report_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PMU;
    logic [11:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 command = 1'b0;
    logic [31:0]          descriptor_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           event_res;
    logic [11:0]          core_id;
    logic [7:0]           core_revision;
    logic [31:0]          base_address;
    logic [31:0]          wrap_address;
    logic [4:0]           cores_found;

    // scan tracker state, mirrors the parser's registers
    logic [11:0]  pmu_id = PMU_ID_RESET;
    logic [11:0]  gci_id = GCI_ID_RESET;
    scan_phase_t  phase = PH_IDLE;
    logic [11:0]  pending_part = '0;
    logic [7:0]   pending_rev = '0;
    logic         want_master = 1'b0;
    logic [19:0]  found_base = '0;
    logic [19:0]  found_wrap = '0;
    logic         skip_high = 1'b0;
    logic         want_size = 1'b0;
    logic [6:0]   cores_entered = '0;

    core_report_t reports_due[$];
    core_report_t due;
    int           errors = 0;
    int           words_parsed = 0;   // words the parser actually acts on
    bit           idle_on = 1'b1;

    enum_rom_descriptor_parser_core #(
        .MAX_CORES(TABLE_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .descriptor_word(descriptor_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .core_id        (core_id),
        .core_revision  (core_revision),
        .base_address   (base_address),
        .wrap_address   (wrap_address),
        .cores_found    (cores_found)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Scan tracker
    // ------------------------------------------------------------------------
    function automatic void post_report(input logic [1:0] ev, input logic [11:0] id,
                                        input logic [7:0] rev, input logic [31:0] base,
                                        input logic [31:0] wrap);
        core_report_t r;
        r.ev = ev;
        r.id = id;
        r.rev = rev;
        r.base = base;
        r.wrap = wrap;
        r.count = cores_entered[4:0];
        reports_due.push_back(r);
    endfunction

    // Count the pending core, or flag a full table and go idle.
    function automatic void enter_core();
        if (cores_entered >= TABLE_SLOTS)
        begin
            phase = PH_IDLE;
            post_report(EV_FULL, '0, '0, '0, '0);
        end
        else
        begin
            cores_entered++;
            phase = PH_COMP1;
            post_report(EV_CORE, pending_part, pending_rev,
                        {found_base, 12'h000}, {found_wrap, 12'h000});
        end
    endfunction

    // Core is complete once both regions are known and no trailer word is owed.
    function automatic void check_done();
        if (!skip_high && !want_size && found_base != '0 && found_wrap != '0)
            enter_core();
    endfunction

    // Advance the scan by one accepted word. A word handed back by the first
    // descriptor or by an end marker in the address list runs another pass.
    function automatic void track_rom_word(input logic cmd, input logic [31:0] w);
        logic [3:0] kind;
        logic [1:0] size_kind;
        logic [1:0] slave_kind;
        logic [1:0] wrap_kind;
        bit         settled;
        kind = (w[2:0] == DK_ADDR) ? KIND_ADDR : w[3:0];
        settled = 1'b0;
        if (cmd || phase != PH_IDLE)
            words_parsed++;
        if (cmd)
        begin
            phase = PH_COMP1;
            cores_entered = '0;
            pending_part = '0;
            pending_rev = '0;
            want_master = 1'b0;
            found_base = '0;
            found_wrap = '0;
            skip_high = 1'b0;
            want_size = 1'b0;
            return;
        end
        for (int pass = 0; pass < 4 && !settled; pass++)
        begin
            settled = 1'b1;
            case (phase)
                PH_COMP1:
                begin
                    if (kind == DK_END)
                    begin
                        phase = PH_IDLE;
                        post_report(EV_END, '0, '0, '0, '0);
                    end
                    else if (kind == DK_COMP)
                    begin
                        pending_part = w[19:8];
                        phase = PH_COMP2;
                    end
                end
                PH_COMP2:
                begin
                    if (w[3:0] != DK_COMP)
                    begin
                        phase = PH_IDLE;
                        post_report(EV_MALFORMED, '0, '0, '0, '0);
                    end
                    else
                    begin
                        pending_rev = w[31:24];
                        // no wrappers: only the two listed part numbers survive
                        if (w[18:14] == '0 && w[23:19] == '0 &&
                            pending_part != pmu_id && pending_part != gci_id)
                        begin
                            phase = PH_COMP1;
                        end
                        else
                        begin
                            found_base = '0;
                            found_wrap = '0;
                            skip_high = 1'b0;
                            want_size = 1'b0;
                            phase = PH_FIRST;
                        end
                    end
                end
                PH_FIRST:
                begin
                    if (kind == DK_MPORT)
                    begin
                        want_master = 1'b1;
                        phase = PH_SCAN;
                    end
                    else
                    begin
                        // slave port word is itself an address word; anything
                        // else goes back to component search
                        if (kind == KIND_ADDR)
                        begin
                            want_master = 1'b0;
                            phase = PH_SCAN;
                        end
                        else
                        begin
                            phase = PH_COMP1;
                        end
                        settled = 1'b0;
                    end
                end
                PH_SCAN:
                begin
                    if (skip_high)
                    begin
                        skip_high = 1'b0;
                        check_done();
                    end
                    else if (want_size)
                    begin
                        want_size = 1'b0;
                        if (w[3])
                            skip_high = 1'b1;
                        check_done();
                    end
                    else if (kind == DK_END)
                    begin
                        // drops the pending core, marker is rescanned
                        phase = PH_COMP1;
                        settled = 1'b0;
                    end
                    else if (kind == DK_COMP)
                    begin
                        enter_core();
                        if (phase != PH_IDLE)
                        begin
                            pending_part = w[19:8];
                            phase = PH_COMP2;
                        end
                    end
                    else if (kind == KIND_ADDR)
                    begin
                        size_kind = w[5:4];
                        slave_kind = w[7:6];
                        wrap_kind = want_master ? SK_MWRAP : SK_SWRAP;
                        if (w[3])
                            skip_high = 1'b1;
                        if (size_kind == SZ_ANY)
                            want_size = 1'b1;
                        else if (size_kind == SZ_4K || size_kind == SZ_8K)
                        begin
                            if (found_base == '0 && slave_kind == SK_SLAVE)
                                found_base = w[31:12];
                            if (found_wrap == '0 && slave_kind == wrap_kind)
                                found_wrap = w[31:12];
                        end
                        check_done();
                    end
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic logic [31:0] comp_word(input logic [11:0] part);
        logic [31:0] w;
        w = $urandom;
        w[19:8] = part;
        w[3:0] = DK_COMP;
        return w;
    endfunction

    function automatic logic [31:0] comp2_word(input logic [7:0] rev, input logic [4:0] n_mw,
                                               input logic [4:0] n_sw);
        logic [31:0] w;
        w = $urandom;
        w[31:24] = rev;
        w[23:19] = n_sw;
        w[18:14] = n_mw;
        w[3:0] = DK_COMP;
        return w;
    endfunction

    function automatic logic [31:0] addr_word(input logic [19:0] region, input logic [1:0] sk,
                                              input logic [1:0] sz, input logic high);
        logic [31:0] w;
        w = $urandom;
        w[31:12] = region;
        w[7:6] = sk;
        w[5:4] = sz;
        w[3] = high;
        w[2:0] = DK_ADDR;
        return w;
    endfunction

    function automatic logic [31:0] port_word();
        logic [31:0] w;
        w = $urandom;
        w[3:0] = DK_MPORT;
        return w;
    endfunction

    function automatic logic [31:0] end_word();
        logic [31:0] w;
        w = $urandom;
        w[3:0] = DK_END;
        return w;
    endfunction

    // filler between components: neither a component nor an end marker
    function automatic logic [31:0] noise_word();
        logic [31:0] w;
        do
            w = $urandom;
        while (w[3:0] == DK_COMP || w[3:0] == DK_END);
        return w;
    endfunction

    function automatic logic [31:0] malformed_word();
        logic [31:0] w;
        do
            w = $urandom;
        while (w[3:0] == DK_COMP);
        return w;
    endfunction

    // first descriptor that is neither master port nor address word
    function automatic logic [31:0] stray_first_word();
        logic [31:0] w;
        do
            w = $urandom;
        while (w[3:0] == DK_MPORT || w[2:0] == DK_ADDR);
        return w;
    endfunction

    // high address / size trailer content, often zero as in real tables
    function automatic logic [31:0] trailer_word();
        return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    // One word on the input channel; valid stays up into the next call.
    task automatic send_word(input logic cmd, input logic [31:0] w);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        descriptor_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        track_rom_word(cmd, w);
    endtask

    // Drop valid, wait out every pending report, then let the pipe settle.
    task automatic wait_reports_done();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PMU)
            pmu_id = data;
        else
            gci_id = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Region word plus whatever trailer words it announces.
    task automatic send_addr_group(input bit master);
        logic [19:0] region;
        logic [1:0]  sk;
        logic [1:0]  sz;
        logic [31:0] size_w;
        logic        high;
        int          roll;
        region = 20'($urandom_range(0, 20'hfffff));
        if ($urandom_range(0, 9) == 0)
            region = '0;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            sk = SK_SLAVE;
        else if (roll < 8)
            sk = master ? SK_MWRAP : SK_SWRAP;
        else
            sk = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 9);
        if (roll < 6)
            sz = SZ_4K;
        else if (roll < 8)
            sz = SZ_8K;
        else if (roll < 9)
            sz = SZ_ANY;
        else
            sz = SZ_16K;
        high = ($urandom_range(0, 5) == 0);
        send_word(1'b0, addr_word(region, sk, sz, high));
        if (high)
            send_word(1'b0, trailer_word());
        if (sz == SZ_ANY)
        begin
            size_w = $urandom;
            send_word(1'b0, size_w);
            if (size_w[3])
                send_word(1'b0, trailer_word());
        end
    endtask

    // One table: begin word, n_cores component groups, usually an end marker.
    task automatic send_rom_scan(input int n_cores);
        logic [11:0] part;
        logic [4:0]  n_mw;
        logic [4:0]  n_sw;
        bit          master;
        int          roll;
        int          n_addr;
        send_word(1'b1, $urandom);
        for (int c = 0; c < n_cores; c++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(1'b0, noise_word());
            if ($urandom_range(0, 39) == 0)
                send_word(1'b1, $urandom);      // restart mid-table
            roll = $urandom_range(0, 9);
            if (roll == 0)
                part = pmu_id;
            else if (roll == 1)
                part = gci_id;
            else
                part = 12'($urandom_range(0, 4095));
            send_word(1'b0, comp_word(part));
            if ($urandom_range(0, 29) == 0)
            begin
                send_word(1'b0, malformed_word());
                return;
            end
            n_mw = 5'($urandom_range(0, 3));
            n_sw = 5'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
            begin
                n_mw = '0;
                n_sw = '0;
            end
            send_word(1'b0, comp2_word(8'($urandom_range(0, 255)), n_mw, n_sw));
            roll = $urandom_range(0, 9);
            master = 1'b0;
            if (roll < 7)
            begin
                master = 1'b1;
                send_word(1'b0, port_word());
            end
            else if (roll == 9)
                send_word(1'b0, stray_first_word());
            n_addr = $urandom_range(1, 6);
            for (int a = 0; a < n_addr; a++)
                send_addr_group(master);
        end
        if ($urandom_range(0, 6) != 0)
            send_word(1'b0, end_word());
        if ($urandom_range(0, 4) == 0)
            send_word(1'b0, $urandom);
    endtask

    function automatic int pick_core_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Out of reset the parser waits for a begin; nothing may come out.
    task automatic test_idle_after_reset();
        send_word(1'b0, end_word());
        send_word(1'b0, comp_word(PMU_ID_RESET));
        send_word(1'b0, 32'hffff_ffff);
        send_word(1'b0, 32'h0000_0000);
    endtask

    task automatic test_directed_cores();
        send_word(1'b1, 32'hffff_ffff);
        // widest part and revision, high word and size word skipped
        send_word(1'b0, 32'hffff_fff1);
        send_word(1'b0, comp2_word(8'hff, 5'd1, 5'd1));
        send_word(1'b0, 32'hffff_fff3);
        send_word(1'b0, addr_word(20'hfffff, SK_SLAVE, SZ_4K, 1'b1));
        send_word(1'b0, 32'hffff_ffff);         // end marker swallowed as high word
        send_word(1'b0, addr_word(20'h5a5a5, SK_SLAVE, SZ_ANY, 1'b0));
        send_word(1'b0, 32'h0000_0008);         // size word with its own high word
        send_word(1'b0, 32'h0000_000f);
        send_word(1'b0, addr_word(20'h00001, SK_MWRAP, SZ_4K, 1'b0));
        // power management core without wrappers, slave-port first word,
        // zero base stays unfound, closed by the next component
        send_word(1'b0, comp_word(PMU_ID_RESET));
        send_word(1'b0, comp2_word(8'h00, 5'd0, 5'd0));
        send_word(1'b0, addr_word(20'h00000, SK_SLAVE, SZ_8K, 1'b0));
        send_word(1'b0, addr_word(20'h12345, SK_SWRAP, SZ_8K, 1'b0));
        send_word(1'b0, comp_word(12'h123));
        send_word(1'b0, comp2_word(8'h11, 5'd0, 5'd0));     // dropped, no wrappers
        // coexistence core with a stray first descriptor
        send_word(1'b0, comp_word(GCI_ID_RESET));
        send_word(1'b0, comp2_word(8'h22, 5'd0, 5'd2));
        send_word(1'b0, 32'h0000_0000);
        // end marker inside an address list drops the core and ends the table
        send_word(1'b0, comp_word(12'h456));
        send_word(1'b0, comp2_word(8'h5a, 5'd1, 5'd1));
        send_word(1'b0, port_word());
        send_word(1'b0, addr_word(20'habcde, SK_SLAVE, SZ_4K, 1'b0));
        send_word(1'b0, end_word());
        send_word(1'b0, comp_word(12'h789));  // idle again
    endtask

    task automatic test_directed_terminals();
        send_word(1'b1, 32'h0);
        send_word(1'b0, comp_word(12'h321));
        send_word(1'b0, 32'h0000_0000);         // malformed second word
        // begin in the middle of a scan clears it
        send_word(1'b1, 32'h0);
        send_word(1'b0, comp_word(12'h777));
        send_word(1'b0, comp2_word(8'h01, 5'd1, 5'd0));
        send_word(1'b1, 32'hffff_ffff);
        send_word(1'b0, end_word());
        // component right after the port word: core with no addresses
        send_word(1'b1, 32'h0);
        send_word(1'b0, comp_word(12'h0ab));
        send_word(1'b0, comp2_word(8'h80, 5'd1, 5'd1));
        send_word(1'b0, port_word());
        send_word(1'b0, comp_word(12'h0cd));
        send_word(1'b0, comp2_word(8'h7f, 5'd0, 5'd1));
        send_word(1'b0, port_word());
        send_word(1'b0, end_word());
    endtask

    // Both id registers at their extremes; old default id no longer kept.
    task automatic test_config_extremes();
        wait_reports_done();
        write_reg(CFG_PMU, 12'h000);
        write_reg(CFG_GCI, 12'hfff);
        send_word(1'b1, 32'h0);
        send_word(1'b0, comp_word(12'h000));
        send_word(1'b0, comp2_word(8'h10, 5'd0, 5'd0));
        send_word(1'b0, port_word());
        send_word(1'b0, addr_word(20'h00abc, SK_SLAVE, SZ_4K, 1'b0));
        send_word(1'b0, addr_word(20'h00def, SK_MWRAP, SZ_8K, 1'b0));
        send_word(1'b0, comp_word(12'hfff));
        send_word(1'b0, comp2_word(8'h20, 5'd0, 5'd0));
        send_word(1'b0, addr_word(20'h10000, SK_SWRAP, SZ_4K, 1'b0));
        send_word(1'b0, addr_word(20'h20000, SK_SLAVE, SZ_4K, 1'b0));
        send_word(1'b0, comp_word(PMU_ID_RESET));
        send_word(1'b0, comp2_word(8'h30, 5'd0, 5'd0));
        send_word(1'b0, end_word());
    endtask

    // One core more than the table holds.
    task automatic test_table_full();
        send_word(1'b1, 32'h0);
        for (int c = 0; c <= TABLE_SLOTS; c++)
        begin
            send_word(1'b0, comp_word(12'($urandom_range(0, 4095))));
            send_word(1'b0, comp2_word(8'($urandom_range(0, 255)), 5'd1, 5'd1));
            send_word(1'b0, port_word());
            send_word(1'b0, addr_word(20'($urandom_range(1, 20'hfffff)),
                                      SK_SLAVE, SZ_4K, 1'b0));
            send_word(1'b0, addr_word(20'($urandom_range(1, 20'hfffff)),
                                      SK_MWRAP, SZ_4K, 1'b0));
        end
        send_word(1'b0, end_word());
    endtask

    task automatic test_random_scans();
        int stop_at;
        int roll;
        stop_at = words_parsed + RANDOM_WORDS;
        while (words_parsed < stop_at)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                wait_reports_done();
                roll = $urandom_range(0, 3);
                write_reg(CFG_PMU, (roll == 0) ? 12'h000 : 12'($urandom_range(0, 4095)));
                write_reg(CFG_GCI, (roll == 1) ? pmu_id : 12'($urandom_range(0, 4095)));
            end
            send_rom_scan(pick_core_count());
        end
    endtask

    // Tail of the run with both sides always ready.
    task automatic test_quiet_scans();
        int stop_at;
        idle_on = 1'b0;
        stop_at = words_parsed + QUIET_WORDS;
        while (words_parsed < stop_at)
            send_rom_scan($urandom_range(1, 5));
    endtask

    // ------------------------------------------------------------------------
    // Report side: random stall bursts, checker
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!idle_on)
            begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] gotv);
        if (gotv !== expv)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, gotv);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("report with none pending: event_res 0x%0h", event_res);
                errors++;
            end
            else
            begin
                due = reports_due.pop_front();
                check_field("event_res", 32'(due.ev), 32'(event_res));
                check_field("core_id", 32'(due.id), 32'(core_id));
                check_field("core_revision", 32'(due.rev), 32'(core_revision));
                check_field("base_address", due.base, base_address);
                check_field("wrap_address", due.wrap, wrap_address);
                check_field("cores_found", 32'(due.count), 32'(cores_found));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_directed_cores();
        test_directed_terminals();
        test_config_extremes();
        test_table_full();
        test_random_scans();
        test_quiet_scans();
        wait_reports_done();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
